@@ src/utf16_to_utf8_escaping_encoder_core_assert.svh @@
// Assertion macros for the encoder checker.
`ifndef UTF16_TO_UTF8_ESCAPING_ENCODER_CORE_ASSERT_SVH
`define UTF16_TO_UTF8_ESCAPING_ENCODER_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, checked in and out of reset.
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

// Same, but not checked while the active-low reset is asserted.
`define ASSERT_NEXT_RST(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/utf8enc_pkg.sv @@
// Types, constants and the per-unit UTF-8 encode function of the encoder.
package utf8enc_pkg;

  localparam int unsigned MAX_BYTES = 5;

  // name modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_NICK  = 2'd1;
  localparam logic [1:0] MODE_CHAN  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_NAME_MODE   = 2'd0;
  localparam logic [1:0] REG_ESC_CTRL    = 2'd1;
  localparam logic [1:0] REG_ESC_WILD    = 2'd2;

  // prefix phase
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;

  typedef struct packed {
    logic [1:0]      cnt;    // 1..3
    logic [2:0][7:0] bytes;  // bytes[0] goes out first
  } enc_t;

  function automatic enc_t encode_unit(input logic [15:0] u, input logic esc_c,
                                       input logic esc_w);
    enc_t       e;
    logic [7:0] esc;
    e   = '0;
    esc = 8'h00;
    if (esc_c) begin
      priority if (u == {8'h00, CH_LF})    esc = CH_LC_N;
      else if (u == {8'h00, CH_CR})        esc = CH_LC_R;
      else if (u == {8'h00, CH_TAB})       esc = CH_LC_T;
      else if (u == {8'h00, CH_SPACE})     esc = CH_LC_B;
      else if (u == {8'h00, CH_COMMA})     esc = CH_LC_C;
      else if (u == {8'h00, CH_BSL})       esc = CH_BSL;
      else                                 esc = 8'h00;
    end
    if (esc == 8'h00 && esc_w) begin
      priority if (u == {8'h00, CH_STAR})  esc = CH_STAR;
      else if (u == {8'h00, CH_QMARK})     esc = CH_QMARK;
      else                                 esc = 8'h00;
    end
    priority if (esc != 8'h00) begin
      e.cnt      = 2'd2;
      e.bytes[0] = CH_BSL;
      e.bytes[1] = esc;
    end else if (u <= 16'h007F) begin
      e.cnt      = 2'd1;
      e.bytes[0] = u[7:0];
    end else if (u <= 16'h07FF) begin
      e.cnt      = 2'd2;
      e.bytes[0] = {3'b110, u[10:6]};
      e.bytes[1] = {2'b10, u[5:0]};
    end else begin
      e.cnt      = 2'd3;
      e.bytes[0] = {4'b1110, u[15:12]};
      e.bytes[1] = {2'b10, u[11:6]};
      e.bytes[2] = {2'b10, u[5:0]};
    end
    return e;
  endfunction

endpackage

@@ src/utf16_to_utf8_escaping_encoder_core.sv @@
// UTF-16 to UTF-8 encoder with escaping and name prefixes: top level.
//
// Input channel (in_valid/in_ready) carries one 16-bit code unit per beat;
// in_last_unit marks the final unit of a string. Output channel
// (out_valid/out_ready) carries one UTF-8 byte per beat; out_last_byte is
// set on the final byte of the string. Each unit yields 1 to 5 bytes
// (prefix, escape pair or 1/2/3-byte UTF-8 form).
// Config registers (cfg_we/cfg_index/cfg_data): 0 name_mode, 1 escape
// controls, 2 escape wildcards; write them only while the block is idle.
// The first byte of an accepted unit goes through the byte buffer and then
// the output register. Throughput is one output byte per cycle while
// out_ready is high, set by the single byte-wide output register. A new
// unit is accepted in the same cycle the last byte of the previous one
// moves to the output. Reset (rst_n low, synchronous) clears the config
// registers, the prefix phase and both pipeline stages. When out_ready is
// low the output byte holds, the byte buffer holds, and in_ready drops
// once the buffer is full.
module utf16_to_utf8_escaping_encoder_core
  import utf8enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);

  logic [1:0] name_mode_r;
  logic       esc_ctrl_r;
  logic       esc_wild_r;
  logic [1:0] phase_r, phase_nxt;

  logic [MAX_BYTES-1:0][7:0] work_byte_r, work_byte_nxt;
  logic [2:0]                work_cnt_r, work_cnt_nxt;
  logic                      work_last_r, work_last_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic       in_acc, out_load;
  logic       hash_amp, is_pct;
  enc_t       enc;
  logic [1:0][7:0] pre;
  logic [1:0] pre_cnt;
  logic       body_en;
  logic [2:0] item_cnt;
  logic [2:0] j;
  logic [MAX_BYTES-1:0][7:0] item_bytes;

  assign out_load = (work_cnt_r != 3'd0) && (!out_valid_r || out_ready);
  assign in_ready = (work_cnt_r == 3'd0) || ((work_cnt_r == 3'd1) && out_load);
  assign in_acc   = in_valid && in_ready;

  // build the byte list for the incoming unit
  always_comb begin
    hash_amp  = (in_code_unit == {8'h00, CH_HASH}) || (in_code_unit == {8'h00, CH_AMP});
    is_pct    = (in_code_unit == {8'h00, CH_PCT});
    enc       = encode_unit(in_code_unit, esc_ctrl_r, esc_wild_r);
    pre       = '0;
    pre_cnt   = 2'd0;
    body_en   = 1'b1;
    phase_nxt = PH_BODY;
    priority if (name_mode_r == MODE_CHAN && phase_r == PH_START) begin
      pre[0] = CH_PCT;
      if (is_pct) begin
        // leading percent consumed; a lone one still gets the hash
        pre[1]    = CH_HASH;
        pre_cnt   = in_last_unit ? 2'd2 : 2'd1;
        body_en   = 1'b0;
        phase_nxt = PH_PCT;
      end else begin
        pre[1]  = hash_amp ? in_code_unit[7:0] : CH_HASH;
        pre_cnt = 2'd2;
        body_en = !hash_amp;
      end
    end else if (name_mode_r == MODE_CHAN && phase_r == PH_PCT) begin
      pre[0]  = hash_amp ? in_code_unit[7:0] : CH_HASH;
      pre_cnt = 2'd1;
      body_en = !hash_amp;
    end else if (name_mode_r == MODE_NICK && phase_r == PH_START) begin
      pre[0]  = CH_QUOTE;
      pre_cnt = 2'd1;
    end else begin
      pre_cnt = 2'd0;
    end
    if (in_last_unit) phase_nxt = PH_START;

    item_cnt = {1'b0, pre_cnt} + (body_en ? {1'b0, enc.cnt} : 3'd0);
    for (int i = 0; i < MAX_BYTES; i++) begin
      j = 3'(i) - {1'b0, pre_cnt};
      if (3'(i) < {1'b0, pre_cnt}) item_bytes[i] = pre[i[0]];
      else if (j < 3'd3)           item_bytes[i] = enc.bytes[j[1:0]];
      else                         item_bytes[i] = 8'h00;
    end
  end

  // byte buffer and output register
  always_comb begin
    work_byte_nxt = work_byte_r;
    work_cnt_nxt  = work_cnt_r;
    work_last_nxt = work_last_r;
    if (in_acc) begin
      work_byte_nxt = item_bytes;
      work_cnt_nxt  = item_cnt;
      work_last_nxt = in_last_unit;
    end else if (out_load) begin
      work_byte_nxt = work_byte_r >> 8;
      work_cnt_nxt  = work_cnt_r - 3'd1;
    end

    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = work_byte_r[0];
      out_last_nxt  = work_last_r && (work_cnt_r == 3'd1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_mode_r <= MODE_PLAIN;
      esc_ctrl_r  <= 1'b0;
      esc_wild_r  <= 1'b0;
      phase_r     <= PH_START;
      work_cnt_r  <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NAME_MODE: name_mode_r <= cfg_data;
          REG_ESC_CTRL:  esc_ctrl_r  <= cfg_data[0];
          REG_ESC_WILD:  esc_wild_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) phase_r <= phase_nxt;
      work_cnt_r  <= work_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_byte_r <= work_byte_nxt;
    work_last_r <= work_last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

@@ src/utf8enc_checker.sv @@
// Port-level checker for the encoder and its bind.
`include "utf16_to_utf8_escaping_encoder_core_assert.svh"

module utf8enc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last_byte
);

  // a stalled output beat holds
  `ASSERT_NEXT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last_byte))
  // reset empties the output register
  `ASSERT_NEXT(a_rst_out_empty, clk, !rst_n, !out_valid)
  // reset empties the byte buffer, so input is taken right away
  `ASSERT_NEXT(a_rst_in_ready, clk, !rst_n, in_ready)
  // input blocked with an empty output register means bytes are pending
  `ASSERT_NEXT_RST(a_pending_moves, clk, rst_n, !out_valid && !in_ready, out_valid)

endmodule

bind utf16_to_utf8_escaping_encoder_core utf8enc_checker u_utf8enc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_last_byte (out_last_byte)
);

@@ dv/utf16_to_utf8_escaping_encoder_core_test.sv @@
// Self-checking testbench for the UTF-16 to UTF-8 escaping encoder core.
`timescale 1ns / 100ps

module utf16_to_utf8_escaping_encoder_core_test;
  import utf8enc_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SQUEEZE_LEN   = 120;
  localparam int IDLE_PCT      = 9;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } code_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = REG_NAME_MODE;
  logic [1:0]  cfg_data      = 2'd0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [15:0] in_code_unit  = 16'h0000;
  logic        in_last_unit  = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_byte;

  code_beat_t  code_q[$];
  utf8_beat_t  utf8_expected_q[$];
  code_beat_t  next_code;
  utf8_beat_t  want;

  // encoder model state and its copy of the registers
  logic [1:0]  enc_mode      = MODE_PLAIN;
  logic        enc_esc_ctrl  = 1'b0;
  logic        enc_esc_wild  = 1'b0;
  logic [1:0]  enc_phase     = PH_START;
  logic [7:0]  enc_buf[8];
  int          enc_cnt;

  logic        in_beat       = 1'b0;
  int          units_queued  = 0;
  int          units_taken   = 0;
  int          mismatches    = 0;
  int          quiet_cycles  = 0;
  int          hold_left     = 0;
  bit          hold_done     = 1'b0;
  bit          squeeze_req   = 1'b0;
  bit          idle_ok;

  utf16_to_utf8_escaping_encoder_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_unit (in_code_unit),
    .in_last_unit (in_last_unit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte)
  );

  always #2 clk = ~clk;

  // a stretch of the run with no idling on either side
  assign idle_ok = !(units_taken >= 300 && units_taken < 380);

  function automatic logic [15:0] ascii(input logic [7:0] c);
    return {8'h00, c};
  endfunction

  function void put_byte(input logic [7:0] b);
    if (enc_cnt < 8) begin
      enc_buf[enc_cnt] = b;
      enc_cnt++;
    end
  endfunction

  function void encode_char(input logic [15:0] u);
    logic [7:0] esc;
    esc = 8'h00;
    if (enc_esc_ctrl) begin
      case (u)
        ascii(CH_LF):    esc = CH_LC_N;
        ascii(CH_CR):    esc = CH_LC_R;
        ascii(CH_TAB):   esc = CH_LC_T;
        ascii(CH_SPACE): esc = CH_LC_B;
        ascii(CH_COMMA): esc = CH_LC_C;
        ascii(CH_BSL):   esc = CH_BSL;
        default:         esc = 8'h00;
      endcase
    end
    if (esc == 8'h00 && enc_esc_wild) begin
      if (u == ascii(CH_STAR))       esc = CH_STAR;
      else if (u == ascii(CH_QMARK)) esc = CH_QMARK;
    end
    if (esc != 8'h00) begin
      put_byte(CH_BSL);
      put_byte(esc);
    end else if (u < 16'h0080) begin
      put_byte(u[7:0]);
    end else if (u < 16'h0800) begin
      put_byte(8'hC0 | {3'b000, u[10:6]});
      put_byte(8'h80 | {2'b00, u[5:0]});
    end else begin
      put_byte(8'hE0 | {4'h0, u[15:12]});
      put_byte(8'h80 | {2'b00, u[11:6]});
      put_byte(8'h80 | {2'b00, u[5:0]});
    end
  endfunction

  // channel name: '#' or '&' passes through, anything else gets '#' in front
  function void channel_lead(input logic [15:0] u);
    if (u == ascii(CH_HASH) || u == ascii(CH_AMP)) begin
      put_byte(u[7:0]);
    end else begin
      put_byte(CH_HASH);
      encode_char(u);
    end
  endfunction

  function void predict_utf8(input logic [15:0] u, input logic last);
    int k;
    enc_cnt = 0;
    if (enc_mode == MODE_CHAN && enc_phase == PH_START) begin
      put_byte(CH_PCT);
      if (u == ascii(CH_PCT)) begin
        if (last) put_byte(CH_HASH);
        else enc_phase = PH_PCT;
      end else begin
        channel_lead(u);
        enc_phase = PH_BODY;
      end
    end else if (enc_mode == MODE_CHAN && enc_phase == PH_PCT) begin
      channel_lead(u);
      enc_phase = PH_BODY;
    end else if (enc_mode == MODE_NICK && enc_phase == PH_START) begin
      put_byte(CH_QUOTE);
      encode_char(u);
      enc_phase = PH_BODY;
    end else begin
      encode_char(u);
      enc_phase = PH_BODY;
    end
    if (last) enc_phase = PH_START;
    if (enc_cnt > MAX_BYTES) enc_cnt = MAX_BYTES;
    for (k = 0; k < enc_cnt; k++)
      utf8_expected_q.push_back('{data: enc_buf[k], last: last && (k == enc_cnt - 1)});
  endfunction

  function automatic logic [15:0] rand_code();
    int sel;
    logic [15:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      case ($urandom_range(0, 11))
        0:       c = ascii(CH_LF);
        1:       c = ascii(CH_CR);
        2:       c = ascii(CH_TAB);
        3:       c = ascii(CH_SPACE);
        4:       c = ascii(CH_COMMA);
        5:       c = ascii(CH_BSL);
        6:       c = ascii(CH_STAR);
        7:       c = ascii(CH_QMARK);
        8:       c = ascii(CH_PCT);
        9:       c = ascii(CH_HASH);
        10:      c = ascii(CH_AMP);
        default: c = ascii(CH_QUOTE);
      endcase
    end else if (sel < 55) begin
      c = 16'($urandom_range(16'h0001, 16'h007F));
    end else if (sel < 70) begin
      c = 16'($urandom_range(16'h0080, 16'h07FF));
    end else if (sel < 82) begin
      c = 16'($urandom_range(16'h0800, 16'hFFFF));
    end else if (sel < 90) begin
      c = 16'($urandom_range(16'hD800, 16'hDFFF));
    end else begin
      case ($urandom_range(0, 5))
        0:       c = 16'h0001;
        1:       c = 16'h007F;
        2:       c = 16'h0080;
        3:       c = 16'h07FF;
        4:       c = 16'h0800;
        default: c = 16'hFFFF;
      endcase
    end
    return c;
  endfunction

  task automatic add_code(input logic [15:0] c, input logic last);
    code_q.push_back('{code: c, last: last});
    units_queued++;
  endtask

  // one string of n units; open leaves it unterminated across a phase change
  task automatic add_string(input int n, input bit open);
    logic [15:0] c;
    bit lead_pct;
    lead_pct = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i == 0 && $urandom_range(0, 99) < 35) begin
        c = ascii(CH_PCT);
        lead_pct = 1'b1;
      end else if (i == 1 && lead_pct && $urandom_range(0, 99) < 50) begin
        c = $urandom_range(0, 1) ? ascii(CH_HASH) : ascii(CH_AMP);
      end else begin
        c = rand_code();
      end
      add_code(c, (i == n - 1) && !open);
    end
  endtask

  // wait until every queued unit is taken and every expected byte has come
  task automatic drain();
    while (code_q.size() != 0 || units_taken != units_queued || utf8_expected_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic ctrl, input logic wild);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NAME_MODE;
    cfg_data  <= mode;
    @(negedge clk);
    cfg_index <= REG_ESC_CTRL;
    cfg_data  <= {1'b0, ctrl};
    @(negedge clk);
    cfg_index <= REG_ESC_WILD;
    cfg_data  <= {1'b0, wild};
    @(negedge clk);
    cfg_we    <= 1'b0;
    enc_mode     = mode;
    enc_esc_ctrl = ctrl;
    enc_esc_wild = wild;
  endtask

  task automatic run_phase(input logic [1:0] mode, input logic ctrl, input logic wild,
                           input int nunits, input bit squeeze);
    int added;
    int len;
    bit open;
    added = 0;
    set_config(mode, ctrl, wild);
    while (added < nunits) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      open = (added + len >= nunits) && ($urandom_range(0, 3) == 0);
      add_string(len, open);
      added += len;
    end
    if (squeeze) squeeze_req = 1'b1;
    drain();
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (code_q.size() != 0 && !(idle_ok && $urandom_range(0, 99) < IDLE_PCT)) begin
        next_code = code_q.pop_front();
        in_code_unit <= next_code.code;
        in_last_unit <= next_code.last;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so the block backs up into its input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (squeeze_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= SQUEEZE_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_ok && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // output check first, then prediction for the unit taken on this edge
  always @(posedge clk) begin
    in_beat = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (utf8_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: byte %h last %b", out_byte, out_last_byte);
      end else begin
        want = utf8_expected_q.pop_front();
        if (out_byte !== want.data || out_last_byte !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     want.data, want.last, out_byte, out_last_byte);
        end
      end
    end
    if (in_beat) begin
      predict_utf8(in_code_unit, in_last_unit);
      units_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL utf16_to_utf8_escaping_encoder_core");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // code point boundaries and surrogates
    set_config(MODE_PLAIN, 1'b0, 1'b0);
    add_code(16'h0001, 1'b0);
    add_code(16'h007F, 1'b0);
    add_code(16'h0080, 1'b0);
    add_code(16'h07FF, 1'b0);
    add_code(16'h0800, 1'b0);
    add_code(16'hD800, 1'b0);
    add_code(16'hFFFF, 1'b1);
    drain();

    // both escape sets
    set_config(MODE_PLAIN, 1'b1, 1'b1);
    add_code(ascii(CH_LF), 1'b0);
    add_code(ascii(CH_CR), 1'b0);
    add_code(ascii(CH_TAB), 1'b0);
    add_code(ascii(CH_SPACE), 1'b0);
    add_code(ascii(CH_COMMA), 1'b0);
    add_code(ascii(CH_BSL), 1'b0);
    add_code(ascii(CH_STAR), 1'b0);
    add_code(ascii(CH_QMARK), 1'b1);
    drain();

    set_config(MODE_NICK, 1'b0, 1'b0);
    add_code(ascii(8'h41), 1'b0);
    add_code(ascii(8'h42), 1'b1);
    drain();

    // channel prefixes: lone percent, passed '#' and '&', inserted '#'
    set_config(MODE_CHAN, 1'b1, 1'b0);
    add_code(ascii(CH_PCT), 1'b1);
    add_code(ascii(CH_PCT), 1'b0);
    add_code(ascii(CH_HASH), 1'b1);
    add_code(ascii(CH_PCT), 1'b0);
    add_code(ascii(CH_AMP), 1'b0);
    add_code(ascii(8'h78), 1'b1);
    add_code(ascii(8'h61), 1'b1);
    add_code(ascii(CH_PCT), 1'b0);
    drain();

    // mode switch while a consumed percent is pending
    set_config(MODE_PLAIN, 1'b0, 1'b0);
    add_code(ascii(8'h7A), 1'b1);
    drain();

    run_phase(MODE_PLAIN, 1'b0, 1'b0, 38, 1'b0);
    run_phase(MODE_CHAN,  1'b1, 1'b1, 38, 1'b0);
    run_phase(MODE_NICK,  1'b1, 1'b1, 60, 1'b1);
    run_phase(MODE_CHAN,  1'b0, 1'b0, 38, 1'b0);
    run_phase(MODE_PLAIN, 1'b1, 1'b0, 38, 1'b0);
    run_phase(MODE_NICK,  1'b0, 1'b1, 38, 1'b0);
    for (int p = 0; p < 4; p++)
      run_phase(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 38, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("PASS utf16_to_utf8_escaping_encoder_core");
    else
      $display("FAIL utf16_to_utf8_escaping_encoder_core");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/utf8enc_pkg.sv
src/utf16_to_utf8_escaping_encoder_core.sv
src/utf8enc_checker.sv
dv/utf16_to_utf8_escaping_encoder_core_test.sv
